// File: rtl/smvm_pkg.sv
// Shared widths, codes and types for the streaming mean, variance and min/max block.
package smvm_pkg;

   localparam int SAMPLE_BITS    = 24;
   localparam int MAX_ITEMS      = 1048576;
   localparam int INDEX_BITS     = $clog2(MAX_ITEMS);
   localparam int COUNT_BITS     = INDEX_BITS + 1;
   localparam int DIFF_BITS      = SAMPLE_BITS + 1;
   localparam int SQ_BITS        = 2 * DIFF_BITS - 1;
   localparam int VAR_OUT_BITS   = SQ_BITS + 1;
   localparam int ABS_SUM_BITS   = DIFF_BITS + INDEX_BITS;
   localparam int ABS_OUT_BITS   = DIFF_BITS;
   localparam int DIV_BITS       = SQ_BITS;
   localparam int DIV_CNT_BITS   = $clog2(DIV_BITS + 1);
   localparam int SQ_CNT_BITS    = $clog2(DIFF_BITS + 1);
   localparam int STATUS_BITS    = 2;
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = SAMPLE_BITS;

   localparam logic [STATUS_BITS-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_SINGLE   = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_OVERFLOW = 2'd2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_REFERENCE_MEAN = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNBIASED       = 1'd1;

   typedef struct packed {
      logic                  start;
      logic [DIV_BITS-1:0]   dividend;
      logic [COUNT_BITS-1:0] divisor;
   } div_req_type;

endpackage

// File: rtl/stream_mean_variance_minmax.sv
// Top level of the streaming mean, variance, absolute deviation and min/max block.
//
// Each sample transaction occupies the block from the cycle in which it is accepted through
// a shift-and-add square of the deviation from the reference mean (the deviation is at
// most 25 bits), a step that forms the variance step and starts its divide, a restoring
// divide of that step by the running count, which is the path that sets the rate, and a
// step that applies the mean and variance steps. The divide of the mean step runs on a
// second divider alongside the square. A sample with last set then has both dividers work
// out the absolute deviation and the unbiased correction in parallel, and the result is
// loaded into the output registers. A result waiting on the response channel does not stop
// the next data set from being accepted; only the loading of the following result waits
// for it to be taken. Samples that arrive after the maximum count are dropped and flag the
// result with the overflow status. Configuration writes are expected only while the block
// is idle.
module stream_mean_variance_minmax (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [smvm_pkg::SAMPLE_BITS-1:0]   req_sample,
   input  logic                                  req_last,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [smvm_pkg::SAMPLE_BITS-1:0]   rsp_mean,
   output logic [smvm_pkg::VAR_OUT_BITS-1:0]     rsp_variance,
   output logic [smvm_pkg::ABS_OUT_BITS-1:0]     rsp_abs_deviation,
   output logic signed [smvm_pkg::SAMPLE_BITS-1:0]   rsp_minimum,
   output logic signed [smvm_pkg::SAMPLE_BITS-1:0]   rsp_maximum,
   output logic [smvm_pkg::INDEX_BITS-1:0]       rsp_min_position,
   output logic [smvm_pkg::INDEX_BITS-1:0]       rsp_max_position,
   output logic [smvm_pkg::COUNT_BITS-1:0]       rsp_sample_count,
   output logic [smvm_pkg::STATUS_BITS-1:0]      rsp_status,
   input  logic                                  csr_write_enable,
   input  logic [smvm_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [smvm_pkg::CSR_DATA_BITS-1:0]    csr_data
);
   import smvm_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SQUARE = 3'd1;
   localparam logic [2:0] ST_VDIV   = 3'd2;
   localparam logic [2:0] ST_FSTART = 3'd3;
   localparam logic [2:0] ST_FWAIT  = 3'd4;

   // Control and configuration.
   logic [2:0]             state_ff, state_in;
   logic [SAMPLE_BITS-1:0] ref_mean_ff, ref_mean_in;
   logic                   unbiased_ff, unbiased_in;
   logic                   last_ff, last_in;
   logic                   mean_neg_ff, mean_neg_in;

   // Running statistics.
   logic [SAMPLE_BITS-1:0]  mean_ff, mean_in;
   logic [SQ_BITS-1:0]      var_ff, var_in;
   logic [ABS_SUM_BITS-1:0] abs_sum_ff, abs_sum_in;
   logic [SAMPLE_BITS-1:0]  min_ff, min_in;
   logic [SAMPLE_BITS-1:0]  max_ff, max_in;
   logic [INDEX_BITS-1:0]   min_pos_ff, min_pos_in;
   logic [INDEX_BITS-1:0]   max_pos_ff, max_pos_in;
   logic [COUNT_BITS-1:0]   count_ff, count_in;
   logic                    overflow_ff, overflow_in;

   // Bit-serial squarer.
   logic [SQ_BITS-1:0]     sq_acc_ff, sq_acc_in;
   logic [SQ_BITS-1:0]     sq_mcand_ff, sq_mcand_in;
   logic [DIFF_BITS-1:0]   sq_mplier_ff, sq_mplier_in;
   logic [SQ_CNT_BITS-1:0] sq_cnt_ff, sq_cnt_in;

   // Response registers.
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_BITS-1:0]  rsp_mean_ff, rsp_mean_in;
   logic [VAR_OUT_BITS-1:0] rsp_variance_ff, rsp_variance_in;
   logic [ABS_OUT_BITS-1:0] rsp_abs_ff, rsp_abs_in;
   logic [SAMPLE_BITS-1:0]  rsp_min_ff, rsp_min_in;
   logic [SAMPLE_BITS-1:0]  rsp_max_ff, rsp_max_in;
   logic [INDEX_BITS-1:0]   rsp_min_pos_ff, rsp_min_pos_in;
   logic [INDEX_BITS-1:0]   rsp_max_pos_ff, rsp_max_pos_in;
   logic [COUNT_BITS-1:0]   rsp_count_ff, rsp_count_in;
   logic [STATUS_BITS-1:0]  rsp_status_ff, rsp_status_in;

   // Dividers.
   div_req_type         div_a_req, div_b_req;
   logic                div_a_busy, div_b_busy;
   logic [DIV_BITS-1:0] div_a_quot, div_b_quot;

   // Datapath helpers.
   logic                   accept;
   logic                   full;
   logic [DIFF_BITS-1:0]   x_ext;
   logic [DIFF_BITS-1:0]   mean_diff, mean_mag;
   logic [DIFF_BITS-1:0]   dev_diff, dev_mag;
   logic [COUNT_BITS-1:0]  count_next;
   logic                   var_neg;
   logic [SQ_BITS-1:0]     var_mag;
   logic [DIFF_BITS-1:0]   mean_step;
   logic                   dividers_idle;
   logic                   load_rsp;

   smvm_div u_div_a (
      .clock    (clock),
      .reset    (reset),
      .req      (div_a_req),
      .busy     (div_a_busy),
      .quotient (div_a_quot)
   );

   smvm_div u_div_b (
      .clock    (clock),
      .reset    (reset),
      .req      (div_b_req),
      .busy     (div_b_busy),
      .quotient (div_b_quot)
   );

   assign req_ready     = (state_ff == ST_IDLE);
   assign accept        = req_valid && req_ready;
   assign full          = (count_ff >= COUNT_BITS'(MAX_ITEMS));
   assign dividers_idle = !div_a_busy && !div_b_busy;
   // A finished result is only loaded once the previous one has left.
   assign load_rsp      = (state_ff == ST_FWAIT) && dividers_idle
                          && (!rsp_valid_ff || rsp_ready);

   // Deviations of the incoming sample from the running and the reference mean.
   always_comb begin
      x_ext      = {req_sample[SAMPLE_BITS-1], req_sample};
      mean_diff  = x_ext - {mean_ff[SAMPLE_BITS-1], mean_ff};
      mean_mag   = mean_diff[DIFF_BITS-1] ? DIFF_BITS'(-mean_diff) : mean_diff;
      dev_diff   = x_ext - {ref_mean_ff[SAMPLE_BITS-1], ref_mean_ff};
      dev_mag    = dev_diff[DIFF_BITS-1] ? DIFF_BITS'(-dev_diff) : dev_diff;
      count_next = count_ff + 1'b1;
      var_neg    = (sq_acc_ff < var_ff);
      var_mag    = var_neg ? (var_ff - sq_acc_ff) : (sq_acc_ff - var_ff);
      mean_step  = mean_neg_ff ? DIFF_BITS'(-div_a_quot[DIFF_BITS-1:0])
                               : div_a_quot[DIFF_BITS-1:0];
   end

   always_comb begin
      state_in     = state_ff;
      ref_mean_in  = ref_mean_ff;
      unbiased_in  = unbiased_ff;
      last_in      = last_ff;
      mean_neg_in  = mean_neg_ff;
      mean_in      = mean_ff;
      var_in       = var_ff;
      abs_sum_in   = abs_sum_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      min_pos_in   = min_pos_ff;
      max_pos_in   = max_pos_ff;
      count_in     = count_ff;
      overflow_in  = overflow_ff;
      sq_acc_in    = sq_acc_ff;
      sq_mcand_in  = sq_mcand_ff;
      sq_mplier_in = sq_mplier_ff;
      sq_cnt_in    = sq_cnt_ff;
      div_a_req    = '0;
      div_b_req    = '0;

      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_REFERENCE_MEAN: ref_mean_in = csr_data[SAMPLE_BITS-1:0];
            CSR_UNBIASED:       unbiased_in = csr_data[0];
            default:            ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               last_in = req_last;
               if (full) begin
                  // Samples beyond the maximum count are dropped.
                  overflow_in = 1'b1;
                  if (req_last) begin
                     state_in = ST_FSTART;
                  end
               end else begin
                  count_in   = count_next;
                  abs_sum_in = abs_sum_ff + ABS_SUM_BITS'(dev_mag);
                  if (count_ff == '0) begin
                     min_in     = req_sample;
                     max_in     = req_sample;
                     min_pos_in = '0;
                     max_pos_in = '0;
                  end else begin
                     if ($signed(req_sample) < $signed(min_ff)) begin
                        min_in     = req_sample;
                        min_pos_in = count_ff[INDEX_BITS-1:0];
                     end
                     if ($signed(req_sample) > $signed(max_ff)) begin
                        max_in     = req_sample;
                        max_pos_in = count_ff[INDEX_BITS-1:0];
                     end
                  end
                  mean_neg_in        = mean_diff[DIFF_BITS-1];
                  div_a_req.start    = 1'b1;
                  div_a_req.dividend = DIV_BITS'(mean_mag);
                  div_a_req.divisor  = count_next;
                  sq_acc_in          = '0;
                  sq_mcand_in        = SQ_BITS'(dev_mag);
                  sq_mplier_in       = dev_mag;
                  sq_cnt_in          = SQ_CNT_BITS'(DIFF_BITS);
                  state_in           = ST_SQUARE;
               end
            end
         end
         ST_SQUARE: begin
            if (sq_cnt_ff != '0) begin
               if (sq_mplier_ff[0]) begin
                  sq_acc_in = sq_acc_ff + sq_mcand_ff;
               end
               sq_mcand_in  = {sq_mcand_ff[SQ_BITS-2:0], 1'b0};
               sq_mplier_in = {1'b0, sq_mplier_ff[DIFF_BITS-1:1]};
               sq_cnt_in    = sq_cnt_ff - 1'b1;
            end else begin
               div_b_req.start    = 1'b1;
               div_b_req.dividend = var_mag;
               div_b_req.divisor  = count_ff;
               state_in           = ST_VDIV;
            end
         end
         ST_VDIV: begin
            if (dividers_idle) begin
               mean_in  = mean_ff + mean_step[SAMPLE_BITS-1:0];
               var_in   = var_neg ? (var_ff - div_b_quot) : (var_ff + div_b_quot);
               state_in = last_ff ? ST_FSTART : ST_IDLE;
            end
         end
         ST_FSTART: begin
            div_a_req.start    = 1'b1;
            div_a_req.dividend = DIV_BITS'(abs_sum_ff);
            div_a_req.divisor  = count_ff;
            if (unbiased_ff && (count_ff > COUNT_BITS'(1))) begin
               div_b_req.start    = 1'b1;
               div_b_req.dividend = var_ff;
               div_b_req.divisor  = count_ff - 1'b1;
            end
            state_in = ST_FWAIT;
         end
         ST_FWAIT: begin
            if (load_rsp) begin
               // The data set is closed: clear the running statistics but not the configuration.
               mean_in     = '0;
               var_in      = '0;
               abs_sum_in  = '0;
               min_in      = '0;
               max_in      = '0;
               min_pos_in  = '0;
               max_pos_in  = '0;
               count_in    = '0;
               overflow_in = 1'b0;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result assembly from the closing divides.
   always_comb begin
      rsp_valid_in    = rsp_valid_ff;
      rsp_mean_in     = rsp_mean_ff;
      rsp_variance_in = rsp_variance_ff;
      rsp_abs_in      = rsp_abs_ff;
      rsp_min_in      = rsp_min_ff;
      rsp_max_in      = rsp_max_ff;
      rsp_min_pos_in  = rsp_min_pos_ff;
      rsp_max_pos_in  = rsp_max_pos_ff;
      rsp_count_in    = rsp_count_ff;
      rsp_status_in   = rsp_status_ff;
      if (load_rsp) begin
         rsp_valid_in    = 1'b1;
         rsp_mean_in     = mean_ff;
         rsp_abs_in      = div_a_quot[ABS_OUT_BITS-1:0];
         rsp_min_in      = min_ff;
         rsp_max_in      = max_ff;
         rsp_min_pos_in  = min_pos_ff;
         rsp_max_pos_in  = max_pos_ff;
         rsp_count_in    = count_ff;
         rsp_status_in   = STATUS_OK;
         rsp_variance_in = {1'b0, var_ff};
         if (unbiased_ff) begin
            if (count_ff <= COUNT_BITS'(1)) begin
               // The unbiased estimate is undefined for a single sample.
               rsp_variance_in = '1;
               rsp_status_in   = STATUS_SINGLE;
            end else begin
               rsp_variance_in = {1'b0, var_ff} + {1'b0, div_b_quot};
            end
         end
         if (overflow_ff) begin
            rsp_status_in = STATUS_OVERFLOW;
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ref_mean_ff  <= '0;
         unbiased_ff  <= 1'b1;
         last_ff      <= 1'b0;
         mean_ff      <= '0;
         var_ff       <= '0;
         abs_sum_ff   <= '0;
         min_ff       <= '0;
         max_ff       <= '0;
         min_pos_ff   <= '0;
         max_pos_ff   <= '0;
         count_ff     <= '0;
         overflow_ff  <= 1'b0;
         sq_cnt_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ref_mean_ff  <= ref_mean_in;
         unbiased_ff  <= unbiased_in;
         last_ff      <= last_in;
         mean_ff      <= mean_in;
         var_ff       <= var_in;
         abs_sum_ff   <= abs_sum_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         min_pos_ff   <= min_pos_in;
         max_pos_ff   <= max_pos_in;
         count_ff     <= count_in;
         overflow_ff  <= overflow_in;
         sq_cnt_ff    <= sq_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mean_neg_ff     <= mean_neg_in;
      sq_acc_ff       <= sq_acc_in;
      sq_mcand_ff     <= sq_mcand_in;
      sq_mplier_ff    <= sq_mplier_in;
      rsp_mean_ff     <= rsp_mean_in;
      rsp_variance_ff <= rsp_variance_in;
      rsp_abs_ff      <= rsp_abs_in;
      rsp_min_ff      <= rsp_min_in;
      rsp_max_ff      <= rsp_max_in;
      rsp_min_pos_ff  <= rsp_min_pos_in;
      rsp_max_pos_ff  <= rsp_max_pos_in;
      rsp_count_ff    <= rsp_count_in;
      rsp_status_ff   <= rsp_status_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_mean          = rsp_mean_ff;
   assign rsp_variance      = rsp_variance_ff;
   assign rsp_abs_deviation = rsp_abs_ff;
   assign rsp_minimum       = rsp_min_ff;
   assign rsp_maximum       = rsp_max_ff;
   assign rsp_min_position  = rsp_min_pos_ff;
   assign rsp_max_position  = rsp_max_pos_ff;
   assign rsp_sample_count  = rsp_count_ff;
   assign rsp_status        = rsp_status_ff;

endmodule

// File: rtl/smvm_div.sv
// Restoring bit-serial divider: one quotient bit per clock cycle.
module smvm_div (
   input  logic                          clock,
   input  logic                          reset,
   input  smvm_pkg::div_req_type         req,
   output logic                          busy,
   output logic [smvm_pkg::DIV_BITS-1:0] quotient
);
   import smvm_pkg::*;

   logic                    busy_ff, busy_in;
   logic [DIV_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [DIV_BITS-1:0]     work_ff, work_in;
   logic [COUNT_BITS-1:0]   rem_ff, rem_in;
   logic [COUNT_BITS-1:0]   divisor_ff, divisor_in;
   logic [COUNT_BITS:0]     shifted;
   logic [COUNT_BITS:0]     trial;

   // The dividend shifts out at the top while quotient bits enter at the bottom.
   always_comb begin
      shifted    = {rem_ff, work_ff[DIV_BITS-1]};
      trial      = shifted - {1'b0, divisor_ff};
      busy_in    = busy_ff;
      cnt_in     = cnt_ff;
      work_in    = work_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      if (req.start) begin
         busy_in    = 1'b1;
         cnt_in     = DIV_CNT_BITS'(DIV_BITS);
         work_in    = req.dividend;
         rem_in     = '0;
         divisor_in = req.divisor;
      end else if (busy_ff) begin
         cnt_in  = cnt_ff - 1'b1;
         busy_in = (cnt_ff != DIV_CNT_BITS'(1));
         if (!trial[COUNT_BITS]) begin
            rem_in  = trial[COUNT_BITS-1:0];
            work_in = {work_ff[DIV_BITS-2:0], 1'b1};
         end else begin
            rem_in  = shifted[COUNT_BITS-1:0];
            work_in = {work_ff[DIV_BITS-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      work_ff    <= work_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign busy     = busy_ff;
   assign quotient = work_ff;

endmodule

// File: test/stream_mean_variance_minmax_tb.sv
// Self-checking testbench for the streaming mean, variance, absolute deviation and min/max block.
`timescale 1ns / 1ps

module stream_mean_variance_minmax_tb;
   import smvm_pkg::*;

   // The settle time is long enough for any sample or closing work in flight in the block
   // to finish before the registers change.
   localparam int SETTLE_CYCLES = 200;
   // The watchdog gives up after this many cycles without a single transaction on either
   // channel. The slowest legitimate gap is the long receiver hold-off below.
   localparam int QUIET_LIMIT = 20000;
   localparam int HOLD_CYCLES = 1500;
   localparam int RANDOM_ITEMS_PER_PHASE = 135;
   localparam int REPORT_LIMIT = 10;

   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   localparam longint unsigned VARIANCE_CEILING = (64'd1 << VAR_OUT_BITS) - 64'd1;
   localparam longint unsigned ABS_DEV_CEILING = (64'd1 << ABS_OUT_BITS) - 64'd1;
   localparam longint SQUARE_CAP = 64'sd1 <<< 62;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          last;
   } sample_item_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] mean;
      logic [VAR_OUT_BITS-1:0]       variance;
      logic [ABS_OUT_BITS-1:0]       abs_deviation;
      logic signed [SAMPLE_BITS-1:0] minimum;
      logic signed [SAMPLE_BITS-1:0] maximum;
      logic [INDEX_BITS-1:0]         min_position;
      logic [INDEX_BITS-1:0]         max_position;
      logic [COUNT_BITS-1:0]         sample_count;
      logic [STATUS_BITS-1:0]        status;
   } set_statistics_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic signed [SAMPLE_BITS-1:0] req_sample = '0;
   logic                          req_last = 1'b0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic signed [SAMPLE_BITS-1:0] rsp_mean;
   logic [VAR_OUT_BITS-1:0]       rsp_variance;
   logic [ABS_OUT_BITS-1:0]       rsp_abs_deviation;
   logic signed [SAMPLE_BITS-1:0] rsp_minimum;
   logic signed [SAMPLE_BITS-1:0] rsp_maximum;
   logic [INDEX_BITS-1:0]         rsp_min_position;
   logic [INDEX_BITS-1:0]         rsp_max_position;
   logic [COUNT_BITS-1:0]         rsp_sample_count;
   logic [STATUS_BITS-1:0]        rsp_status;
   logic                          csr_write_enable = 1'b0;
   logic [CSR_INDEX_BITS-1:0]     csr_index = '0;
   logic [CSR_DATA_BITS-1:0]      csr_data = '0;

   // Samples waiting to be offered, and the statistics that each closed data set should
   // produce, oldest first.
   sample_item_type    sample_backlog[$];
   set_statistics_type expected_stats[$];
   int                 error_count = 0;

   // Idling percentages, changed only between phases.
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;

   // The stimulus process bumps the request count; the receiver notices the difference and
   // starts a hold-off that it times itself.
   int hold_requests = 0;
   int holds_served;
   int hold_left;
   int quiet_cycles;

   // Register copies and the running state of the data set, kept at full precision.
   longint          reference_point = 0;
   bit              unbiased_on = 1'b1;
   longint          mean_acc;
   longint          var_acc;
   longint unsigned abs_acc;
   longint          min_val;
   longint          max_val;
   longint unsigned min_pos;
   longint unsigned max_pos;
   longint unsigned seen_count;
   bit              overflow_seen;

   sample_item_type next_item;

   stream_mean_variance_minmax DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_sample        (req_sample),
      .req_last          (req_last),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_mean          (rsp_mean),
      .rsp_variance      (rsp_variance),
      .rsp_abs_deviation (rsp_abs_deviation),
      .rsp_minimum       (rsp_minimum),
      .rsp_maximum       (rsp_maximum),
      .rsp_min_position  (rsp_min_position),
      .rsp_max_position  (rsp_max_position),
      .rsp_sample_count  (rsp_sample_count),
      .rsp_status        (rsp_status),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always #10 clock = ~clock;

   // Wipes the per-set state, as the block does after every result and at reset.
   function automatic void clear_set_state();
      mean_acc = 0;
      var_acc = 0;
      abs_acc = 0;
      min_val = 0;
      max_val = 0;
      min_pos = 0;
      max_pos = 0;
      seen_count = 0;
      overflow_seen = 1'b0;
   endfunction

   // Folds one accepted sample into the running statistics and, when it closes the data
   // set, queues the statistics the block must report.
   function automatic void predict_set_statistics(input logic signed [SAMPLE_BITS-1:0] sample,
                                                  input logic last);
      longint             x;
      longint             n;
      longint             dev;
      longint             square;
      longint unsigned    magnitude;
      longint unsigned    spread;
      longint unsigned    mean_abs;
      set_statistics_type want;

      x = sample;
      if (seen_count >= MAX_ITEMS) begin
         // Past the capacity the sample is dropped, but the set is marked.
         overflow_seen = 1'b1;
      end else begin
         seen_count++;
         n = longint'(seen_count);
         // Signed division in SystemVerilog truncates toward zero, as the block does.
         mean_acc += (x - mean_acc) / n;
         dev = x - reference_point;
         magnitude = (dev < 0) ? longint'(-dev) : longint'(dev);
         square = (magnitude >= (64'd1 << 31)) ? SQUARE_CAP : longint'(magnitude * magnitude);
         var_acc += (square - var_acc) / n;
         abs_acc += magnitude;
         // The first sample seeds both extremes; later ones replace them only when strictly
         // beyond, so each position is the first occurrence.
         if (seen_count == 1) begin
            min_val = x;
            max_val = x;
            min_pos = 0;
            max_pos = 0;
         end else begin
            if (x < min_val) begin
               min_val = x;
               min_pos = seen_count - 1;
            end
            if (x > max_val) begin
               max_val = x;
               max_pos = seen_count - 1;
            end
         end
      end

      if (!last) return;

      want.status = STATUS_OK;
      spread = (var_acc < 0) ? 64'd0 : longint'(var_acc);
      if (unbiased_on) begin
         if (seen_count <= 1) begin
            // A single sample has no unbiased variance: saturate and flag it.
            spread = VARIANCE_CEILING;
            want.status = STATUS_SINGLE;
         end else begin
            spread = spread + spread / (seen_count - 1);
         end
      end
      if (spread > VARIANCE_CEILING) spread = VARIANCE_CEILING;
      mean_abs = (seen_count != 0) ? abs_acc / seen_count : 64'd0;
      if (mean_abs > ABS_DEV_CEILING) mean_abs = ABS_DEV_CEILING;
      if (overflow_seen) want.status = STATUS_OVERFLOW;

      want.mean          = mean_acc[SAMPLE_BITS-1:0];
      want.variance      = spread[VAR_OUT_BITS-1:0];
      want.abs_deviation = mean_abs[ABS_OUT_BITS-1:0];
      want.minimum       = min_val[SAMPLE_BITS-1:0];
      want.maximum       = max_val[SAMPLE_BITS-1:0];
      want.min_position  = min_pos[INDEX_BITS-1:0];
      want.max_position  = max_pos[INDEX_BITS-1:0];
      want.sample_count  = seen_count[COUNT_BITS-1:0];
      expected_stats.push_back(want);
      clear_set_state();
   endfunction

   function automatic void compare_field(input string name, input logic [63:0] want,
                                         input logic [63:0] got);
      if (got !== want) begin
         error_count++;
         if (error_count <= REPORT_LIMIT)
            $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, name, want, got);
      end
   endfunction

   // Matches the result transaction on the outputs against the oldest expectation.
   function automatic void check_set_statistics();
      set_statistics_type want;

      if (expected_stats.size() == 0) begin
         error_count++;
         if (error_count <= REPORT_LIMIT)
            $display("%0t: result transaction with nothing expected, count %0d",
                     $realtime, rsp_sample_count);
         return;
      end
      want = expected_stats.pop_front();
      compare_field("mean", want.mean, rsp_mean);
      compare_field("variance", want.variance, rsp_variance);
      compare_field("abs_deviation", want.abs_deviation, rsp_abs_deviation);
      compare_field("minimum", want.minimum, rsp_minimum);
      compare_field("maximum", want.maximum, rsp_maximum);
      compare_field("min_position", want.min_position, rsp_min_position);
      compare_field("max_position", want.max_position, rsp_max_position);
      compare_field("sample_count", want.sample_count, rsp_sample_count);
      compare_field("status", want.status, rsp_status);
   endfunction

   // Sender. A transaction is predicted at the edge that accepts it. A new sample is only
   // put up once the previous one has gone, and valid is never dropped while waiting.
   // Between transactions the payload carries noise that the block must ignore.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) predict_set_statistics(req_sample, req_last);
         if (!req_valid || req_ready) begin
            if (sample_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               next_item = sample_backlog.pop_front();
               req_valid  <= 1'b1;
               req_sample <= next_item.sample;
               req_last   <= next_item.last;
            end else begin
               req_valid  <= 1'b0;
               req_sample <= SAMPLE_BITS'($urandom());
               req_last   <= 1'($urandom_range(1));
            end
         end
      end
   end

   // Receiver. Results are checked at the edge that accepts them. A requested hold-off keeps
   // ready low for a long stretch so that the block backs up into its input.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left <= 0;
         holds_served <= 0;
      end else begin
         if (rsp_valid && rsp_ready) check_set_statistics();
         if (holds_served != hold_requests) begin
            holds_served <= hold_requests;
            hold_left <= HOLD_CYCLES;
            rsp_ready <= 1'b0;
         end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
         end
      end
   end

   // Watchdog: any transaction on either channel counts as progress.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $realtime, QUIET_LIMIT);
         $display("** stream_mean_variance_minmax: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic write_register(input logic [CSR_INDEX_BITS-1:0] index,
                                 input logic [CSR_DATA_BITS-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (index == CSR_REFERENCE_MEAN) reference_point = longint'($signed(value));
      else if (index == CSR_UNBIASED) unbiased_on = value[0];
   endtask

   task automatic apply_settings(input logic signed [SAMPLE_BITS-1:0] reference,
                                 input bit unbiased);
      write_register(CSR_REFERENCE_MEAN, reference);
      write_register(CSR_UNBIASED, CSR_DATA_BITS'(unbiased));
   endtask

   task automatic queue_sample(input logic signed [SAMPLE_BITS-1:0] sample, input logic last);
      sample_item_type item;

      item.sample = sample;
      item.last = last;
      sample_backlog.push_back(item);
   endtask

   // Mostly full-range values, with the extremes and tight clusters mixed in so that small
   // variances and repeated extremes turn up as well.
   function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
      case ($urandom_range(9))
         0: return $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
         1, 2: return SAMPLE_BITS'($signed($urandom_range(64)) - 32);
         3: return SAMPLE_BITS'(reference_point + $signed($urandom_range(2000)) - 1000);
         default: return SAMPLE_BITS'($urandom());
      endcase
   endfunction

   // Queues whole data sets until the item count is reached. Most sets are short so that
   // results are plentiful; now and then a longer one exercises the running recurrences.
   task automatic queue_random_sets(input int items);
      int queued;
      int length;

      queued = 0;
      while (queued < items) begin
         length = ($urandom_range(9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
         for (int i = 0; i < length; i++) queue_sample(pick_sample(), i == length - 1);
         queued += length;
      end
   endtask

   // Waits on the falling edge so that every transaction of the rising edge is settled,
   // then lets any trailing work inside the block finish.
   task automatic wait_until_drained();
      do @(negedge clock);
      while (sample_backlog.size() != 0 || req_valid || expected_stats.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_idling(input int sender_pct, input int receiver_pct);
      sender_idle_pct = sender_pct;
      receiver_stall_pct = receiver_pct;
   endtask

   initial begin
      clear_set_state();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Phase one: reset values of the registers, written explicitly all the same.
      set_idling(22, 69);
      apply_settings('0, 1'b1);
      // A lone sample with unbiased scaling saturates the variance and flags the set.
      queue_sample(SAMPLE_MAX, 1'b1);
      queue_sample(SAMPLE_MIN, 1'b1);
      // Both extremes, each repeated later, so the positions must stay at the first index.
      queue_sample(SAMPLE_MAX, 1'b0);
      queue_sample(SAMPLE_MIN, 1'b0);
      queue_sample('0, 1'b0);
      queue_sample(SAMPLE_BITS'(-1), 1'b0);
      queue_sample(SAMPLE_BITS'(1), 1'b0);
      queue_sample(SAMPLE_MAX, 1'b0);
      queue_sample(SAMPLE_MIN, 1'b1);
      // Identical samples: zero deviation spread, both positions at zero.
      for (int i = 0; i < 3; i++) queue_sample(SAMPLE_BITS'(5), i == 2);
      queue_random_sets(RANDOM_ITEMS_PER_PHASE);
      wait_until_drained();

      // Phase two: reference at the top, biased variance. The lowest sample gives the
      // largest possible deviation, and a lone sample must not saturate here.
      apply_settings(SAMPLE_MAX, 1'b0);
      queue_sample(SAMPLE_MIN, 1'b0);
      queue_sample(SAMPLE_MIN, 1'b1);
      queue_sample(SAMPLE_MIN, 1'b1);
      queue_random_sets(RANDOM_ITEMS_PER_PHASE);
      wait_until_drained();

      // Phase three: reference at the bottom, unbiased again, idling swapped round.
      set_idling(69, 22);
      apply_settings(SAMPLE_MIN, 1'b1);
      queue_sample(SAMPLE_MAX, 1'b0);
      queue_sample(SAMPLE_MAX, 1'b0);
      queue_sample(SAMPLE_MIN, 1'b1);
      queue_sample('0, 1'b1);
      queue_random_sets(RANDOM_ITEMS_PER_PHASE);
      wait_until_drained();

      apply_settings(SAMPLE_BITS'($urandom()), 1'b0);
      queue_random_sets(RANDOM_ITEMS_PER_PHASE);
      wait_until_drained();

      // Phase five: no idling. The receiver first holds off for a long stretch while a run
      // of single-sample sets keeps arriving, so that a finished result blocks the next one
      // and the block stops taking samples.
      set_idling(0, 0);
      apply_settings(SAMPLE_BITS'($urandom()), 1'b1);
      for (int i = 0; i < 30; i++) queue_sample(pick_sample(), 1'b1);
      hold_requests++;
      // The sender then pauses until every outstanding result has been delivered.
      wait_until_drained();
      queue_random_sets(RANDOM_ITEMS_PER_PHASE);
      wait_until_drained();

      apply_settings('0, 1'b0);
      queue_random_sets(RANDOM_ITEMS_PER_PHASE);
      wait_until_drained();

      if (error_count == 0) begin
         $display("** stream_mean_variance_minmax: PASSED **");
      end else begin
         $display("** stream_mean_variance_minmax: FAILED **");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/smvm_pkg.sv
rtl/smvm_div.sv
rtl/stream_mean_variance_minmax.sv
test/stream_mean_variance_minmax_tb.sv
